### rtl/core/tsbe_pkg.sv
// Shared types, constants and arithmetic helpers for the tagged stack executor.
package tsbe_pkg;
	localparam int StackDepth = 256;
	localparam int PoolDepth = 1024;
	localparam int FracBits = 32;
	localparam int SpW = $clog2(StackDepth);
	localparam int CntW = SpW + 1;
	localparam int PiW = $clog2(PoolDepth);
	localparam int QueueDepth = 2;

	localparam logic [1:0] TAG_BOOL = 2'd0;
	localparam logic [1:0] TAG_NULL = 2'd1;
	localparam logic [1:0] TAG_NUM = 2'd2;

	localparam logic [1:0] MODE_EXEC = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [7:0] OP_CONST = 8'd0;
	localparam logic [7:0] OP_CONST_LONG = 8'd1;
	localparam logic [7:0] OP_NULL = 8'd2;
	localparam logic [7:0] OP_TRUE = 8'd3;
	localparam logic [7:0] OP_LIT_FALSE = 8'd4;
	localparam logic [7:0] OP_EQ = 8'd5;
	localparam logic [7:0] OP_GT = 8'd6;
	localparam logic [7:0] OP_LT = 8'd7;
	localparam logic [7:0] OP_ADD = 8'd8;
	localparam logic [7:0] OP_SUB = 8'd9;
	localparam logic [7:0] OP_MUL = 8'd10;
	localparam logic [7:0] OP_DIV = 8'd11;
	localparam logic [7:0] OP_NOT = 8'd12;
	localparam logic [7:0] OP_NEG = 8'd13;
	localparam logic [7:0] OP_RET = 8'd14;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_RET = 3'd1;
	localparam logic [2:0] ST_TYPE = 3'd2;
	localparam logic [2:0] ST_UNDER = 3'd3;
	localparam logic [2:0] ST_OVER = 3'd4;

	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

	// Operation classes decided in the front part
	typedef enum logic [3:0] {
		K_NOP, K_PUSH_POOL, K_PUSH_IMM, K_CMP_EQ, K_GT, K_LT, K_ADD, K_SUB,
		K_MUL, K_DIV, K_NOT, K_NEG, K_RET, K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [1:0] tag;     // pool tag or immediate tag
		logic [63:0] value;  // pool payload or immediate payload
	} cmd_t;

	function automatic logic [63:0] sat_mag(input logic neg, input logic [64:0] mag);
		if (!neg) return (mag > {1'b0, SMAX}) ? SMAX : mag[63:0];
		return (mag > {1'b0, SMIN}) ? SMIN : (64'd0 - mag[63:0]);
	endfunction
endpackage

### rtl/core/tagged_stack_bytecode_executor.sv
// Top level of the tagged stack bytecode executor.
// Channel   Dir  Fields (tdata low bit up)                              Extra
// s_axis    in   mode[1:0] opcode[9:2] const_index[19:10] load_tag[21:20]
//                load_value[85:22], zero fill to 88 bits
// m_axis    out  status[2:0] result_tag[4:3] result_value[68:5]
//                stack_depth[77:69], zero fill to 80 bits
// Push, compare, add, sub and the rest pass the back part's RD, EXE and WB states;
// mul and div also wait in WAITMD on the multicycle unit (4 partial products or
// 128 shift-subtract steps).
// Pool loads finish in the front part and pass as no-ops through the back.
// Reset empties the stack; pool and stack memories hold no reset value.
// A held result stalls the back part in write-back only; front and back stall
// on their own through a two-entry command queue.
module tagged_stack_bytecode_executor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // mode, opcode, const_index, load_tag, load_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // status, result_tag, result_value, stack_depth
);
	import tsbe_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready;
	cmd_t f_cmd, q_cmd;
	logic [2:0]  status;
	logic [1:0]  result_tag;
	logic [63:0] result_value;
	logic [8:0]  stack_depth;

	tsbe_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.mode(s_axis_tdata[1:0]), .opcode(s_axis_tdata[9:2]),
		.const_index(s_axis_tdata[19:10]), .load_tag(s_axis_tdata[21:20]),
		.load_value(s_axis_tdata[85:22]),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	tsbe_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
	);

	tsbe_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(status), .result_tag(result_tag),
		.result_value(result_value), .stack_depth(stack_depth)
	);

	assign m_axis_tdata = {2'b00, stack_depth, result_value, result_tag, status};
endmodule

### rtl/core/tsbe_front.sv
// Front part: pool memory, pool writes and classification of opcodes into commands.
module tsbe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  logic [7:0]        opcode,
	input  logic [9:0]        const_index,
	input  logic [1:0]        load_tag,
	input  logic [63:0]       load_value,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output tsbe_pkg::cmd_t    cmd
);
	import tsbe_pkg::*;

	logic [1:0]  pool_tag_mem [PoolDepth];
	logic [63:0] pool_val_mem [PoolDepth];

	logic        vld_s1;
	kind_t       kind_s1;
	logic [1:0]  tag_s1;
	logic [63:0] val_s1;
	logic        use_pool_s1;
	logic [1:0]  rd_tag_s1;
	logic [63:0] rd_val_s1;

	logic [9:0]  idx;
	logic        idx_ok;
	kind_t       kind_c;
	logic [1:0]  tag_c;
	logic [63:0] val_c;
	logic        use_pool_c;
	logic [1:0]  ld_tag;
	logic [63:0] ld_val;

	assign in_ready = !vld_s1 || cmd_ready;

	always_comb begin
		idx = (opcode == OP_CONST) ? {2'b00, const_index[7:0]} : const_index;
		idx_ok = ({1'b0, idx} < 11'(PoolDepth));
		kind_c = K_NOP;
		tag_c = TAG_NULL;
		val_c = '0;
		use_pool_c = 1'b0;
		unique case (mode)
			MODE_EXEC: begin
				unique case (opcode)
					OP_CONST, OP_CONST_LONG: begin
						kind_c = K_PUSH_POOL;
						use_pool_c = idx_ok;
					end
					OP_NULL: kind_c = K_PUSH_IMM;
					OP_TRUE: begin
						kind_c = K_PUSH_IMM;
						tag_c = TAG_BOOL;
						val_c = 64'd1;
					end
					OP_LIT_FALSE: begin
						kind_c = K_PUSH_IMM;
						tag_c = TAG_BOOL;
					end
					OP_EQ: kind_c = K_CMP_EQ;
					OP_GT: kind_c = K_GT;
					OP_LT: kind_c = K_LT;
					OP_ADD: kind_c = K_ADD;
					OP_SUB: kind_c = K_SUB;
					OP_MUL: kind_c = K_MUL;
					OP_DIV: kind_c = K_DIV;
					OP_NOT: kind_c = K_NOT;
					OP_NEG: kind_c = K_NEG;
					OP_RET: kind_c = K_RET;
					default: kind_c = K_NOP;
				endcase
			end
			MODE_CLEAR: kind_c = K_CLEAR;
			default: kind_c = K_NOP;
		endcase
		ld_tag = (load_tag == TAG_BOOL || load_tag == TAG_NUM) ? load_tag : TAG_NULL;
		case (load_tag)
			TAG_BOOL: ld_val = {63'd0, |load_value};
			TAG_NUM: ld_val = load_value;
			default: ld_val = '0;
		endcase
	end

	wire take = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (take && mode == MODE_LOAD && idx_ok) begin
			pool_tag_mem[const_index[PiW-1:0]] <= ld_tag;
			pool_val_mem[const_index[PiW-1:0]] <= ld_val;
		end
		if (take) begin
			rd_tag_s1 <= pool_tag_mem[idx[PiW-1:0]];
			rd_val_s1 <= pool_val_mem[idx[PiW-1:0]];
			kind_s1 <= kind_c;
			tag_s1 <= tag_c;
			val_s1 <= val_c;
			use_pool_s1 <= use_pool_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd.kind = kind_s1;
	assign cmd.tag = use_pool_s1 ? rd_tag_s1 : tag_s1;
	assign cmd.value = use_pool_s1 ? rd_val_s1 : val_s1;
endmodule

### rtl/core/tsbe_queue.sv
// Short command queue between front and back parts.
module tsbe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  tsbe_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output tsbe_pkg::cmd_t rd_cmd
);
	import tsbe_pkg::*;

	cmd_t ent_q [QueueDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	wire push = wr_valid && wr_ready;
	wire pop = rd_valid && rd_ready;

	assign wr_ready = cnt_q != 2'(QueueDepth);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QueueDepth))
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(QueueDepth) && !pop) |=> cnt_q == 2'(QueueDepth))
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
endmodule

### rtl/core/tsbe_muldiv.sv
// Multicycle fixed-point multiply (16x64 partial products) and radix-2 divide.
module tsbe_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);
	import tsbe_pkg::*;

	typedef enum logic [1:0] {IDLE, MUL, DIV, FIN} st_t;
	st_t st_q;
	logic [6:0]   cnt_q;
	logic [63:0]  x_q, y_q;
	logic [127:0] acc_q;   // product or shifted numerator
	logic [127:0] quo_q;
	logic [64:0]  rem_q;
	logic         neg_q, zero_q, azero_q, aneg_q;
	logic [63:0]  res_q;

	logic [63:0] ma, mb;
	logic [79:0] pp;
	logic [64:0] rsh;
	logic [127:0] shifted;
	logic [64:0] mag;

	always_comb begin
		ma = a[63] ? 64'd0 - a : a;
		mb = b[63] ? 64'd0 - b : b;
		pp = 80'(x_q[15:0]) * 80'(y_q);
		rsh = {rem_q[63:0], acc_q[127]};
		shifted = acc_q >> FracBits;
		mag = (st_q == MUL) ? {|shifted[127:64], shifted[63:0]}
		                    : {|quo_q[127:64], quo_q[63:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= (st_q == FIN);
			unique case (st_q)
				IDLE: if (start) begin
					st_q <= is_div ? DIV : MUL;
					cnt_q <= '0;
				end
				MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd4) st_q <= FIN;
				end
				DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) st_q <= FIN;
				end
				FIN: st_q <= IDLE;
				default: st_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			IDLE: begin
				x_q <= ma;
				y_q <= mb;
				neg_q <= a[63] ^ b[63];
				zero_q <= (b == 64'd0);
				azero_q <= (a == 64'd0);
				aneg_q <= a[63];
				acc_q <= is_div ? (128'(ma) << FracBits) : '0;
				quo_q <= '0;
				rem_q <= '0;
			end
			MUL: if (cnt_q < 7'd4) begin
				acc_q <= acc_q + (128'(pp) << (cnt_q[1:0] * 16));
				x_q <= x_q >> 16;
			end else begin
				res_q <= sat_mag(neg_q, mag);
			end
			DIV: begin
				acc_q <= acc_q << 1;
				if (rsh >= {1'b0, y_q}) begin
					rem_q <= rsh - {1'b0, y_q};
					quo_q <= {quo_q[126:0], 1'b1};
				end else begin
					rem_q <= rsh;
					quo_q <= {quo_q[126:0], 1'b0};
				end
			end
			FIN: if (cnt_q != 7'd5) begin
				if (zero_q) res_q <= azero_q ? 64'd0 : (aneg_q ? SMIN : SMAX);
				else res_q <= sat_mag(neg_q, mag);
			end
			default: ;
		endcase
	end

	assign res = res_q;
endmodule

### rtl/core/tsbe_back.sv
// Back part: stack memory, top-of-stack registers, execution and result register.
module tsbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tsbe_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic [1:0]     result_tag,
	output logic [63:0]    result_value,
	output logic [8:0]     stack_depth
);
	import tsbe_pkg::*;

	typedef enum logic [2:0] {IDLE, RD, EXE, WAITMD, WB} st_t;
	st_t st_q;

	logic [1:0]  stag_mem [StackDepth];
	logic [63:0] sval_mem [StackDepth];

	// top entry kept in registers; memory holds entries below it
	logic [CntW-1:0] cnt_q;
	logic [1:0]  ttag_q;
	logic [63:0] tval_q;
	logic [1:0]  ntag_q;   // entry below top, read from memory
	logic [63:0] nval_q;
	cmd_t        c_q;
	logic        md_start;
	logic        md_done;
	logic [63:0] md_res;
	logic        md_div;

	// outcome of the command in flight
	logic [2:0]  st_x;
	logic [1:0]  rtag_x;
	logic [63:0] rval_x;

	// result register, held until the transfer
	logic [2:0]  st_o;
	logic [1:0]  tag_o;
	logic [63:0] val_o;
	logic [8:0]  dep_o;

	logic [2:0]  ex_st;
	logic        md_go;
	logic        wb_fire;

	logic [CntW-1:0] rd_addr;
	assign rd_addr = cnt_q - CntW'(2);

	assign cmd_ready = (st_q == IDLE);
	assign md_div = (c_q.kind == K_DIV);
	assign wb_fire = (st_q == WB) && (!out_valid || out_ready);

	tsbe_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .start(md_start), .is_div(md_div),
		.a(nval_q), .b(tval_q), .done(md_done), .res(md_res)
	);

	logic        eqv, gtv, ltv;
	logic [63:0] sum, dif;
	always_comb begin
		eqv = (ntag_q == ttag_q) && (ntag_q == TAG_NULL || nval_q == tval_q);
		gtv = $signed(tval_q) < $signed(nval_q);
		ltv = $signed(nval_q) < $signed(tval_q);
		sum = nval_q + tval_q;
		if (nval_q[63] == tval_q[63] && sum[63] != nval_q[63])
			sum = nval_q[63] ? SMIN : SMAX;
		dif = nval_q - tval_q;
		if (nval_q[63] != tval_q[63] && dif[63] != nval_q[63])
			dif = nval_q[63] ? SMIN : SMAX;
	end

	always_comb begin
		ex_st = ST_OK;
		unique case (c_q.kind)
			K_PUSH_POOL, K_PUSH_IMM: if (cnt_q == CntW'(StackDepth)) ex_st = ST_OVER;
			K_CMP_EQ, K_GT, K_LT, K_ADD, K_SUB, K_MUL, K_DIV: begin
				if (cnt_q < CntW'(2)) ex_st = ST_UNDER;
				else if (c_q.kind != K_CMP_EQ && (ntag_q != TAG_NUM || ttag_q != TAG_NUM))
					ex_st = ST_TYPE;
			end
			K_NOT: if (cnt_q == '0) ex_st = ST_UNDER;
			K_NEG: begin
				if (cnt_q == '0) ex_st = ST_UNDER;
				else if (ttag_q != TAG_NUM) ex_st = ST_TYPE;
			end
			K_RET: ex_st = (cnt_q == '0) ? ST_UNDER : ST_RET;
			default: ;
		endcase
		md_go = (st_q == EXE) && (c_q.kind == K_MUL || c_q.kind == K_DIV) && ex_st == ST_OK;
	end

	always_ff @(posedge clk) begin
		if (st_q == IDLE && cmd_valid && cmd_ready && cnt_q >= CntW'(2))
			{ntag_q, nval_q} <= {stag_mem[rd_addr[SpW-1:0]], sval_mem[rd_addr[SpW-1:0]]};
		if (st_q == IDLE && cmd_valid && cmd_ready) c_q <= cmd;
		// push of a new top spills the old one
		if (st_q == EXE && (c_q.kind == K_PUSH_POOL || c_q.kind == K_PUSH_IMM)
		    && cnt_q != '0 && cnt_q != CntW'(StackDepth)) begin
			stag_mem[cnt_q[SpW-1:0] - SpW'(1)] <= ttag_q;
			sval_mem[cnt_q[SpW-1:0] - SpW'(1)] <= tval_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			md_start <= 1'b0;
			ttag_q <= TAG_NULL;
			tval_q <= '0;
			st_x <= ST_OK;
			rtag_x <= TAG_NULL;
			rval_x <= '0;
			st_o <= ST_OK;
			tag_o <= TAG_NULL;
			val_o <= '0;
			dep_o <= '0;
		end else begin
			md_start <= md_go;
			if (wb_fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				IDLE: if (cmd_valid && cmd_ready) st_q <= RD;
				RD: st_q <= EXE;
				EXE: begin
					st_q <= md_go ? WAITMD : WB;
					st_x <= ex_st;
					unique case (c_q.kind)
						K_PUSH_POOL, K_PUSH_IMM: begin
							if (cnt_q != CntW'(StackDepth)) begin
								cnt_q <= cnt_q + CntW'(1);
								ttag_q <= c_q.tag;
								tval_q <= c_q.value;
							end
						end
						K_CMP_EQ, K_GT, K_LT, K_ADD, K_SUB, K_MUL, K_DIV: begin
							if (cnt_q < CntW'(2)) ;
							else if (c_q.kind == K_CMP_EQ) begin
								cnt_q <= cnt_q - CntW'(1);
								ttag_q <= TAG_BOOL;
								tval_q <= {63'd0, eqv};
							end else if (ntag_q != TAG_NUM || ttag_q != TAG_NUM) begin
								cnt_q <= '0;
							end else begin
								cnt_q <= cnt_q - CntW'(1);
								unique case (c_q.kind)
									K_GT: begin ttag_q <= TAG_BOOL; tval_q <= {63'd0, gtv}; end
									K_LT: begin ttag_q <= TAG_BOOL; tval_q <= {63'd0, ltv}; end
									K_ADD: tval_q <= sum;
									K_SUB: tval_q <= dif;
									default: ;
								endcase
							end
						end
						K_NOT: begin
							if (cnt_q != '0) begin
								tval_q <= {63'd0, ttag_q == TAG_NULL
								           || (ttag_q == TAG_BOOL && tval_q == '0)};
								ttag_q <= TAG_BOOL;
							end
						end
						K_NEG: begin
							if (cnt_q == '0) ;
							else if (ttag_q != TAG_NUM) cnt_q <= '0;
							else tval_q <= (tval_q == SMIN) ? SMAX : 64'd0 - tval_q;
						end
						K_RET: begin
							if (cnt_q != '0) begin
								cnt_q <= cnt_q - CntW'(1);
								rtag_x <= ttag_q;
								rval_x <= tval_q;
								ttag_q <= ntag_q;
								tval_q <= nval_q;
							end
						end
						K_CLEAR: cnt_q <= '0;
						default: ;
					endcase
				end
				WAITMD: if (md_done) begin
					tval_q <= md_res;
					st_q <= WB;
				end
				// waits here while the previous result is still held
				WB: if (wb_fire) begin
					st_q <= IDLE;
					st_o <= st_x;
					dep_o <= 9'(cnt_q);
					tag_o <= (st_x == ST_RET) ? rtag_x
					         : ((cnt_q == '0) ? TAG_NULL : ttag_q);
					val_o <= (st_x == ST_RET) ? rval_x
					         : ((cnt_q == '0) ? 64'd0 : tval_q);
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign status = st_o;
	assign result_tag = tag_o;
	assign result_value = val_o;
	assign stack_depth = dep_o;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(StackDepth))
		else $error("stack count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == WAITMD) |-> (c_q.kind == K_MUL || c_q.kind == K_DIV))
		else $error("waiting on unit without mul or div");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && st_o == ST_TYPE) |-> dep_o == '0)
		else $error("type error left values on stack");
endmodule

### tb/tagged_stack_bytecode_executor_test.sv
// Self-checking testbench for the tagged stack bytecode executor.
module tagged_stack_bytecode_executor_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tsbe_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] TAG_SPARE = 2'd3;
	localparam logic [7:0] OP_TOP = 8'd255;
	localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;
	localparam int RAND_ITEMS = 800;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] tag;
		logic [63:0] value;
		logic [8:0] depth;
	} outcome_t;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] op;
		logic [9:0] idx;
		logic [1:0] ltag;
		logic [63:0] lval;
		bit typed;
		outcome_t want;
	} step_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [79:0] m_axis_tdata;

	tagged_stack_bytecode_executor dut (.*);

	// shadow machine state
	logic [1:0] stk_tag [StackDepth];
	logic [63:0] stk_val [StackDepth];
	int unsigned depth_now;
	logic [1:0] pool_tag [PoolDepth];
	logic [63:0] pool_val [PoolDepth];
	bit pool_set [PoolDepth];
	int written_idx[$];
	int written_low[$];

	outcome_t pending[$];
	step_t steps[$];
	int errors;
	int cycles;
	bit busy_free;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] sat_q(input bit neg, input logic [127:0] m);
		if (!neg) return (m > {64'd0, SMAX}) ? SMAX : m[63:0];
		return (m > {64'd0, SMIN}) ? SMIN : (64'd0 - m[63:0]);
	endfunction

	function automatic logic [63:0] absval(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, absval(a)} * {64'd0, absval(b)};
		return sat_q(a[63] != b[63], p >> FracBits);
	endfunction

	function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] q;
		if (b == 64'd0) begin
			if (a == 64'd0) return 64'd0;
			return a[63] ? SMIN : SMAX;
		end
		q = ({64'd0, absval(a)} << FracBits) / {64'd0, absval(b)};
		return sat_q(a[63] != b[63], q);
	endfunction

	function automatic logic [2:0] push(input logic [1:0] t, input logic [63:0] v);
		if (depth_now >= StackDepth) return ST_OVER;
		stk_tag[depth_now] = t;
		stk_val[depth_now] = v;
		depth_now++;
		return ST_OK;
	endfunction

	// one item through the shadow machine
	function automatic outcome_t machine_step(input logic [87:0] d);
		logic [1:0] mode, ltag, ta, tb;
		logic [7:0] op;
		logic [9:0] idx;
		logic [63:0] lval, a, b, r;
		outcome_t o;
		mode = d[1:0];
		op = d[9:2];
		idx = d[19:10];
		ltag = d[21:20];
		lval = d[85:22];
		o.status = ST_OK;
		o.tag = TAG_NULL;
		o.value = '0;
		if (mode == MODE_LOAD) begin
			if (ltag == TAG_BOOL) lval = (lval != 0) ? 64'd1 : 64'd0;
			else if (ltag != TAG_NUM) begin
				ltag = TAG_NULL;
				lval = '0;
			end
			pool_tag[idx] = ltag;
			pool_val[idx] = lval;
			if (!pool_set[idx]) begin
				pool_set[idx] = 1'b1;
				written_idx.push_back(idx);
				if (idx < 256) written_low.push_back(idx);
			end
		end else if (mode == MODE_CLEAR) begin
			depth_now = 0;
		end else if (mode == MODE_EXEC) begin
			case (op)
				OP_CONST: o.status = push(pool_tag[idx[7:0]], pool_val[idx[7:0]]);
				OP_CONST_LONG: o.status = push(pool_tag[idx], pool_val[idx]);
				OP_NULL: o.status = push(TAG_NULL, 64'd0);
				OP_TRUE: o.status = push(TAG_BOOL, 64'd1);
				OP_LIT_FALSE: o.status = push(TAG_BOOL, 64'd0);
				OP_EQ, OP_GT, OP_LT, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (depth_now < 2) o.status = ST_UNDER;
					else begin
						ta = stk_tag[depth_now-2];
						tb = stk_tag[depth_now-1];
						a = stk_val[depth_now-2];
						b = stk_val[depth_now-1];
						if (op == OP_EQ) begin
							depth_now -= 2;
							o.status = push(TAG_BOOL,
								((ta == tb) && (ta == TAG_NULL || a == b)) ? 64'd1 : 64'd0);
						end else if (ta != TAG_NUM || tb != TAG_NUM) begin
							depth_now = 0;
							o.status = ST_TYPE;
						end else begin
							depth_now -= 2;
							case (op)
								OP_GT: o.status = push(TAG_BOOL, 64'($signed(a) > $signed(b)));
								OP_LT: o.status = push(TAG_BOOL, 64'($signed(a) < $signed(b)));
								default: begin
									case (op)
										OP_ADD: begin
											r = a + b;
											if (a[63] == b[63] && r[63] != a[63])
												r = a[63] ? SMIN : SMAX;
										end
										OP_SUB: begin
											r = a - b;
											if (a[63] != b[63] && r[63] != a[63])
												r = a[63] ? SMIN : SMAX;
										end
										OP_MUL: r = q_mul(a, b);
										default: r = q_div(a, b);
									endcase
									o.status = push(TAG_NUM, r);
								end
							endcase
						end
					end
				end
				OP_NOT: begin
					if (depth_now < 1) o.status = ST_UNDER;
					else begin
						ta = stk_tag[depth_now-1];
						a = stk_val[depth_now-1];
						depth_now--;
						o.status = push(TAG_BOOL,
							(ta == TAG_NULL || (ta == TAG_BOOL && a == 0)) ? 64'd1 : 64'd0);
					end
				end
				OP_NEG: begin
					if (depth_now < 1) o.status = ST_UNDER;
					else if (stk_tag[depth_now-1] != TAG_NUM) begin
						depth_now = 0;
						o.status = ST_TYPE;
					end else begin
						a = stk_val[depth_now-1];
						stk_val[depth_now-1] = (a == SMIN) ? SMAX : (64'd0 - a);
					end
				end
				OP_RET: begin
					if (depth_now < 1) o.status = ST_UNDER;
					else begin
						depth_now--;
						o.status = ST_RET;
						o.tag = stk_tag[depth_now];
						o.value = stk_val[depth_now];
					end
				end
				default: ;
			endcase
		end
		if (o.status != ST_RET) begin
			if (depth_now > 0) begin
				o.tag = stk_tag[depth_now-1];
				o.value = stk_val[depth_now-1];
			end else begin
				o.tag = TAG_NULL;
				o.value = '0;
			end
		end
		o.depth = depth_now[8:0];
		return o;
	endfunction

	function automatic step_t mk(input logic [1:0] mode, input logic [7:0] op,
			input logic [9:0] idx, input logic [1:0] ltag, input logic [63:0] lval,
			input bit typed = 0, input logic [2:0] st = ST_OK,
			input logic [1:0] tag = TAG_NULL, input logic [63:0] val = '0,
			input logic [8:0] dep = '0);
		step_t s;
		s.mode = mode; s.op = op; s.idx = idx; s.ltag = ltag; s.lval = lval;
		s.typed = typed;
		s.want = '{st, tag, val, dep};
		return s;
	endfunction

	function automatic logic [63:0] rand_q();
		case ($urandom_range(0, 7))
			0: return SMAX;
			1: return SMIN;
			2: return 64'd0;
			3, 4: return 64'($signed($urandom_range(0, 20)) - 10) << FracBits;
			5: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		if (busy_free) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(input step_t s);
		logic [87:0] d;
		outcome_t o;
		int g;
		d = {2'b00, s.lval, s.ltag, s.idx, s.op, s.mode};
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		o = machine_step(d);
		pending.push_back(s.typed ? s.want : o);
	endtask

	function automatic step_t rand_step();
		int r, w;
		logic [7:0] op;
		r = $urandom_range(0, 99);
		if (r < 8)
			return mk(MODE_LOAD, 8'($urandom), 10'($urandom),
				($urandom_range(0, 9) < 6) ? TAG_NUM : 2'($urandom), rand_q());
		if (r < 36) begin
			if ($urandom_range(0, 1) && written_low.size() > 0) begin
				w = written_low[$urandom_range(0, written_low.size()-1)];
				return mk(MODE_EXEC, OP_CONST, {2'($urandom), 8'(w)}, 2'($urandom), rand_q());
			end
			w = written_idx[$urandom_range(0, written_idx.size()-1)];
			return mk(MODE_EXEC, OP_CONST_LONG, 10'(w), 2'($urandom), rand_q());
		end
		if (r < 44) op = 8'($urandom_range(OP_NULL, OP_LIT_FALSE));
		else if (r < 86) op = 8'($urandom_range(OP_EQ, OP_NEG));
		else if (r < 92) op = OP_RET;
		else if (r < 95)
			return mk($urandom_range(0, 1) ? MODE_CLEAR : MODE_SPARE, 8'($urandom),
				10'($urandom), 2'($urandom), rand_q());
		else op = 8'($urandom_range(OP_RET + 1, OP_TOP));
		return mk(MODE_EXEC, op, 10'($urandom), 2'($urandom), rand_q());
	endfunction

	// result side: random backpressure and checking
	always @(posedge clk) begin
		outcome_t got, exp_o;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.tag = m_axis_tdata[4:3];
			got.value = m_axis_tdata[68:5];
			got.depth = m_axis_tdata[77:69];
			if (pending.size() == 0) begin
				$display("%0t: unexpected transfer %h", $realtime, got);
				errors++;
			end else begin
				exp_o = pending.pop_front();
				if (got.status !== exp_o.status)
					$display("%0t: status exp %0d got %0d", $realtime, exp_o.status, got.status);
				if (got.tag !== exp_o.tag)
					$display("%0t: tag exp %0d got %0d", $realtime, exp_o.tag, got.tag);
				if (got.value !== exp_o.value)
					$display("%0t: value exp %h got %h", $realtime, exp_o.value, got.value);
				if (got.depth !== exp_o.depth)
					$display("%0t: depth exp %0d got %0d", $realtime, exp_o.depth, got.depth);
				if (got !== exp_o) errors++;
			end
		end
		if (busy_free) m_axis_tready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0: stall_left = $urandom_range(10, 40);
				1, 2, 3, 4: stall_left = $urandom_range(1, 3);
				default: stall_left = 0;
			endcase
			m_axis_tready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		step_t s;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		errors = 0;
		cycles = 0;
		busy_free = 0;
		stall_left = 0;
		depth_now = 0;
		foreach (pool_set[i]) pool_set[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		steps.push_back(mk(MODE_EXEC, OP_RET, 0, 0, 0, 1, ST_UNDER));
		steps.push_back(mk(MODE_LOAD, 0, 5, TAG_NUM, ONE_Q, 1));
		steps.push_back(mk(MODE_LOAD, 0, 1023, TAG_NUM, SMAX, 1));
		steps.push_back(mk(MODE_LOAD, 0, 0, TAG_SPARE, 64'd123, 1));
		steps.push_back(mk(MODE_LOAD, 0, 300, TAG_BOOL, 64'd77, 1));
		steps.push_back(mk(MODE_LOAD, 0, 7, TAG_NUM, SMIN, 1));
		steps.push_back(mk(MODE_LOAD, 0, 8, TAG_NUM, 64'd0, 1));
		// short const drops the high index bits
		steps.push_back(mk(MODE_EXEC, OP_CONST, 261, 0, 0, 1, ST_OK, TAG_NUM, ONE_Q, 1));
		steps.push_back(mk(MODE_EXEC, OP_CONST_LONG, 1023, 0, 0, 1, ST_OK, TAG_NUM, SMAX, 2));
		steps.push_back(mk(MODE_EXEC, OP_ADD, 0, 0, 0, 1, ST_OK, TAG_NUM, SMAX, 1));
		steps.push_back(mk(MODE_EXEC, OP_CONST_LONG, 7, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_MUL, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_CONST, 5, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_DIV, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_NEG, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_CONST_LONG, 8, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_CONST_LONG, 8, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_DIV, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_CONST_LONG, 8, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_DIV, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_CONST_LONG, 300, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_NOT, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_NULL, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_CONST, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_EQ, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_SUB, 0, 0, 0, 1, ST_TYPE));
		steps.push_back(mk(MODE_EXEC, OP_NOT, 0, 0, 0, 1, ST_UNDER));
		steps.push_back(mk(MODE_EXEC, OP_TRUE, 0, 0, 0));
		steps.push_back(mk(MODE_EXEC, OP_RET, 0, 0, 0));
		steps.push_back(mk(MODE_SPARE, OP_TRUE, 0, 0, 0, 1));
		steps.push_back(mk(MODE_EXEC, OP_TOP, 0, 0, 0, 1));
		steps.push_back(mk(MODE_CLEAR, 0, 0, 0, 0, 1));
		foreach (steps[i]) send(steps[i]);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 150 == 0) busy_free = ($urandom_range(0, 3) == 0);
			if (n == RAND_ITEMS / 2) begin
				// fill the stack past its top to hit overflow
				repeat (StackDepth + 4) send(mk(MODE_EXEC, OP_LIT_FALSE, 0, 0, 0));
				send(mk(MODE_EXEC, OP_CONST_LONG, 1023, 0, 0));
				send(mk(MODE_CLEAR, 0, 0, 0, 0));
			end
			s = rand_step();
			send(s);
		end
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

### filelist.f
rtl/core/tsbe_pkg.sv
rtl/core/tsbe_front.sv
rtl/core/tsbe_queue.sv
rtl/core/tsbe_muldiv.sv
rtl/core/tsbe_back.sv
rtl/core/tagged_stack_bytecode_executor.sv
tb/tagged_stack_bytecode_executor_test.sv
